// ===== src/wsd_pkg.sv =====
// shared types and constants of the websocket frame deframer
`default_nettype none
package wsd_pkg;

   // header parse phases
   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4
   } wsd_phase_type;

   // 7-bit length codes that announce an extended length
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // byte counts of the header extensions
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // one classified beat handed from the parser to the output side
   typedef struct packed {
      logic [7:0] raw_byte;
      logic [7:0] key_byte;
      logic       masked;
      logic [3:0] opcode;
      logic       fin;
      logic       last;
      logic       empty;
   } wsd_item_type;

endpackage
`default_nettype wire

// ===== src/wsd_front.sv =====
// header parser: tracks frame structure and classifies each received byte
`default_nettype none
module wsd_front
   import wsd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic [7:0]   stream_byte,
   output logic              push,
   output wsd_item_type      item
);

   wsd_phase_type phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        fin_ff, fin_in;
   logic        mask_ff, mask_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic [63:0] length_ff, length_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  key_idx_ff, key_idx_in;
   logic [63:0] remaining_ff, remaining_in;

   logic        hdr_done;
   logic        key_done;
   logic        mask_sel;
   logic [7:0]  key_byte;

   always_comb begin
      case (key_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      opcode_in    = opcode_ff;
      fin_in       = fin_ff;
      mask_in      = mask_ff;
      ext_left_in  = ext_left_ff;
      length_in    = length_ff;
      key_in       = key_ff;
      key_idx_in   = key_idx_ff;
      remaining_in = remaining_ff;
      hdr_done     = 1'b0;
      key_done     = 1'b0;
      mask_sel     = mask_ff;
      push         = 1'b0;
      item         = '0;
      item.opcode  = opcode_ff;
      item.fin     = fin_ff;
      if (accept) begin
         case (phase_ff)
            PH_HDR1: begin
               mask_in  = stream_byte[7];
               mask_sel = stream_byte[7];
               if (stream_byte[6:0] == LEN_EXT16 || stream_byte[6:0] == LEN_EXT64) begin
                  ext_left_in = (stream_byte[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                  length_in   = '0;
                  phase_in    = PH_EXT;
               end else begin
                  length_in = {57'd0, stream_byte[6:0]};
                  hdr_done  = 1'b1;
               end
            end
            PH_EXT: begin
               length_in   = {length_ff[55:0], stream_byte};
               ext_left_in = ext_left_ff - 4'd1;
               hdr_done    = (ext_left_ff == 4'd1);
            end
            PH_KEY: begin
               key_in      = {key_ff[23:0], stream_byte};
               ext_left_in = ext_left_ff - 4'd1;
               key_done    = (ext_left_ff == 4'd1);
            end
            PH_DATA: begin
               key_idx_in    = key_idx_ff + 2'd1;
               remaining_in  = remaining_ff - 64'd1;
               push          = 1'b1;
               item.raw_byte = stream_byte;
               item.key_byte = key_byte;
               item.masked   = mask_ff;
               item.last     = (remaining_ff == 64'd1);
               if (remaining_ff == 64'd1) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               fin_in    = stream_byte[7];
               opcode_in = stream_byte[3:0];
               phase_in  = PH_HDR1;
            end
         endcase

         if (hdr_done) begin
            if (mask_sel) begin
               phase_in    = PH_KEY;
               ext_left_in = KEY_BYTES;
               key_in      = '0;
            end else begin
               key_done = 1'b1;
            end
         end

         // header complete: enter payload or emit the empty marker
         if (key_done) begin
            key_idx_in   = '0;
            remaining_in = length_in;
            if (length_in == 64'd0) begin
               phase_in   = PH_HDR0;
               push       = 1'b1;
               item.last  = 1'b1;
               item.empty = 1'b1;
            end else begin
               phase_in = PH_DATA;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         opcode_ff    <= '0;
         fin_ff       <= 1'b0;
         mask_ff      <= 1'b0;
         ext_left_ff  <= '0;
         length_ff    <= '0;
         key_ff       <= '0;
         key_idx_ff   <= '0;
         remaining_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         opcode_ff    <= opcode_in;
         fin_ff       <= fin_in;
         mask_ff      <= mask_in;
         ext_left_ff  <= ext_left_in;
         length_ff    <= length_in;
         key_ff       <= key_in;
         key_idx_ff   <= key_idx_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/wsd_queue.sv =====
// short fifo of classified beats between parser and output side
`default_nettype none
module wsd_queue
   import wsd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire wsd_item_type push_item,
   output logic              full,
   input  wire logic         pop,
   output logic              not_empty,
   output wsd_item_type      head_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   wsd_item_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/wsd_back.sv =====
// output side: unmasks a queued beat into the result register
`default_nettype none
module wsd_back
   import wsd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         head_valid,
   input  wire wsd_item_type head_item,
   output logic              pop,
   output logic              out_valid,
   input  wire logic         out_ready,
   output logic [7:0]        out_byte,
   output logic [3:0]        out_opcode,
   output logic              out_fin,
   output logic              out_last,
   output logic              out_empty
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [3:0] opcode_ff;
   logic       fin_ff;
   logic       last_ff;
   logic       empty_ff;

   assign pop     = head_valid && (!valid_ff || out_ready);
   assign byte_in = head_item.masked ? (head_item.raw_byte ^ head_item.key_byte)
                                     : head_item.raw_byte;

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff   <= byte_in;
         opcode_ff <= head_item.opcode;
         fin_ff    <= head_item.fin;
         last_ff   <= head_item.last;
         empty_ff  <= head_item.empty;
      end
   end

   assign out_valid  = valid_ff;
   assign out_byte   = byte_ff;
   assign out_opcode = opcode_ff;
   assign out_fin    = fin_ff;
   assign out_last   = last_ff;
   assign out_empty  = empty_ff;

endmodule
`default_nettype wire

// ===== src/websocket_frame_deframer.sv =====
// top level of the websocket frame deframer
//
// usage: the received connection stream enters on req_, one byte per beat
// the parser reads the frame header (fin, opcode, mask flag, 7-bit length,
// 16- or 64-bit extended length, masking key); header bytes give no result
// each payload byte leaves on rsp_ unmasked, with opcode and fin in tuser
// rsp_tlast marks the final byte of a frame
// a zero-length frame gives one marker beat with the empty flag set and data 0
// throughput: one byte per cycle while the queue has room, set by the parser
// step (64-bit remaining-count decrement and compare)
// a payload byte passes a queue slot, then the output register, to reach rsp_
// stall: while rsp_tready is low, results collect in the queue; req_tready
// falls only once the queue is full and rises again as beats drain
// reset: synchronous; parser waits for a first header byte, queue and
// output register are emptied, no clearing pass is needed
`default_nettype none
module websocket_frame_deframer
   import wsd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // receive stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] stream_byte
   // deframed payload
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] payload_byte
   output logic             rsp_tlast,   // last_in_frame
   output logic [5:0]       rsp_tuser    // [3:0] frame_opcode, [4] final_fragment, [5] empty_frame
);

   logic         req_accept;
   logic         front_push;
   wsd_item_type front_item;
   logic         queue_full;
   logic         queue_not_empty;
   wsd_item_type queue_head;
   logic         back_pop;
   logic [3:0]   out_opcode;
   logic         out_fin;
   logic         out_empty;

   // bytes are taken whenever the queue has room, header bytes included
   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   wsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .stream_byte (req_tdata),
      .push        (front_push),
      .item        (front_item)
   );

   wsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (back_pop),
      .not_empty (queue_not_empty),
      .head_item (queue_head)
   );

   wsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_not_empty),
      .head_item  (queue_head),
      .pop        (back_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_opcode (out_opcode),
      .out_fin    (out_fin),
      .out_last   (rsp_tlast),
      .out_empty  (out_empty)
   );

   assign rsp_tuser = {out_empty, out_fin, out_opcode};

endmodule
`default_nettype wire

// ===== tb/websocket_frame_deframer_tb.sv =====
// self-checking testbench of the websocket frame deframer: frame stimulus and payload scoreboard
module websocket_frame_deframer_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import wsd_pkg::*;

   localparam int RUN_LIMIT   = 800000;  // cycles before the run is declared hung
   localparam int PHASE_BYTES = 475;     // stream bytes per idling phase
   localparam int DRAIN_WAIT  = 8;       // output passes a queue slot and an output register, keep a margin
   localparam int MAX_GAP     = 40;      // longest sender gap in cycles
   localparam int REPORT_MAX  = 10;      // mismatches printed in full

   // one deframed payload beat as seen on rsp_
   typedef struct packed {
      logic [7:0] payload;
      logic [3:0] opcode;
      logic       fin;
      logic       last;
      logic       empty;
   } payload_beat_type;

   // tracks the frame parser and holds the payload beats still to come
   class frame_board;
      wsd_phase_type    phase;
      logic [3:0]       opcode;
      logic             fin;
      logic             masked;
      logic [3:0]       bytes_left;
      logic [63:0]      length;
      logic [63:0]      remaining;
      logic [31:0]      key;
      logic [1:0]       key_idx;
      payload_beat_type pending_beats[$];
      int               errors;

      function new();
         phase      = PH_HDR0;
         opcode     = '0;
         fin        = 1'b0;
         masked     = 1'b0;
         bytes_left = '0;
         length     = '0;
         remaining  = '0;
         key        = '0;
         key_idx    = '0;
         errors     = 0;
      endfunction

      // header done: either an empty marker or on to the payload
      function void open_payload();
         payload_beat_type marker;
         key_idx   = '0;
         remaining = length;
         if (length == 64'd0) begin
            phase  = PH_HDR0;
            marker = '{payload: 8'd0, opcode: opcode, fin: fin, last: 1'b1, empty: 1'b1};
            pending_beats.insert(pending_beats.size(), marker);
         end else begin
            phase = PH_DATA;
         end
      endfunction

      function void close_length();
         if (masked) begin
            phase      = PH_KEY;
            bytes_left = KEY_BYTES;
            key        = '0;
         end else begin
            open_payload();
         end
      endfunction

      // one accepted stream byte
      function void note_byte(logic [7:0] b);
         payload_beat_type beat;
         logic [7:0]       data;
         case (phase)
            PH_HDR1: begin
               masked = b[7];
               if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                  bytes_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                  length     = '0;
                  phase      = PH_EXT;
               end else begin
                  length = {57'd0, b[6:0]};
                  close_length();
               end
            end
            PH_EXT: begin
               length     = {length[55:0], b};
               bytes_left = bytes_left - 4'd1;
               if (bytes_left == 4'd0) close_length();
            end
            PH_KEY: begin
               key        = {key[23:0], b};
               bytes_left = bytes_left - 4'd1;
               if (bytes_left == 4'd0) open_payload();
            end
            PH_DATA: begin
               data = b;
               // key bytes are applied most significant first
               if (masked) data = b ^ key[8 * (3 - int'(key_idx)) +: 8];
               key_idx   = key_idx + 2'd1;
               remaining = remaining - 64'd1;
               beat = '{payload: data, opcode: opcode, fin: fin,
                        last: (remaining == 64'd0), empty: 1'b0};
               if (remaining == 64'd0) phase = PH_HDR0;
               pending_beats.insert(pending_beats.size(), beat);
            end
            default: begin
               // first header byte; rsv bits are dropped
               fin    = b[7];
               opcode = b[3:0];
               phase  = PH_HDR1;
            end
         endcase
      endfunction

      // one accepted rsp_ beat against the oldest expectation
      function void check_beat(logic [7:0] data, logic last, logic [5:0] user);
         payload_beat_type want;
         payload_beat_type got;
         got = '{payload: data, opcode: user[3:0], fin: user[4], last: last, empty: user[5]};
         if (pending_beats.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("unexpected beat: data %02h op %h fin %b last %b empty %b",
                        got.payload, got.opcode, got.fin, got.last, got.empty);
            return;
         end
         want = pending_beats.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("beat mismatch: data %02h/%02h op %h/%h fin %b/%b last %b/%b empty %b/%b",
                        want.payload, got.payload, want.opcode, got.opcode, want.fin, got.fin,
                        want.last, got.last, want.empty, got.empty);
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] stream_byte
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [7:0] payload_byte
   logic       rsp_tlast;    // last_in_frame
   logic [5:0] rsp_tuser;    // [3:0] frame_opcode, [4] final_fragment, [5] empty_frame

   frame_board board;
   int         sent_bytes;
   int         cycle_count;
   int         idle_pct;     // chance in a hundred that the sender idles a cycle
   int         stall_pct;    // chance in a hundred that the receiver stalls a cycle

   websocket_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // hang guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver backpressure, changed between edges
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // every accepted rsp_ beat goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_beat(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   // one stream byte: optional idle gap, then hold until the beat is taken
   task automatic push_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      board.note_byte(b);
      sent_bytes++;
      @(negedge clock);
   endtask

   // random well-formed frame; lengths stay small so frames close quickly
   task automatic push_frame();
      logic [7:0]  hdr0;
      logic        masked;
      logic [31:0] mask_key;
      int          kind;
      int          len;
      hdr0 = 8'($urandom_range(255));
      // bias toward continuation, text and binary
      if ($urandom_range(1)) hdr0[3:0] = 4'($urandom_range(2));
      masked = 1'($urandom_range(1));
      kind   = $urandom_range(99);
      push_byte(hdr0);
      if (kind < 70) begin
         len = ($urandom_range(3) == 0) ? $urandom_range(125) : $urandom_range(8);
         push_byte({masked, 7'(len)});
      end else if (kind < 90) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(20);
         push_byte({masked, LEN_EXT16});
         push_byte(8'(len >> 8));
         push_byte(8'(len));
      end else begin
         // 64-bit extension, value kept in the low byte
         len = $urandom_range(20);
         push_byte({masked, LEN_EXT64});
         repeat (7) push_byte(8'd0);
         push_byte(8'(len));
      end
      if (masked) begin
         mask_key = $urandom;
         push_byte(mask_key[31:24]);
         push_byte(mask_key[23:16]);
         push_byte(mask_key[15:8]);
         push_byte(mask_key[7:0]);
      end
      repeat (len) push_byte(8'($urandom_range(255)));
   endtask

   initial begin
      board       = new();
      sent_bytes  = 0;
      cycle_count = 0;
      idle_pct    = 0;
      stall_pct   = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'd0;
      rsp_tready  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty unmasked text frame, marker on the second header byte
      push_byte(8'h81);
      push_byte(8'h00);
      // rsv bits set, no fin, masked empty frame: marker on the last key byte
      push_byte(8'h7a);
      push_byte(8'h80);
      push_byte(8'hff);
      push_byte(8'h00);
      push_byte(8'h5a);
      push_byte(8'ha5);
      // non-minimal 16-bit length of zero: marker on the last extension byte
      push_byte(8'h02);
      push_byte({1'b0, LEN_EXT16});
      push_byte(8'h00);
      push_byte(8'h00);
      // 64-bit length of one, unmasked, payload passes through at once
      push_byte(8'h8f);
      push_byte({1'b0, LEN_EXT64});
      repeat (7) push_byte(8'h00);
      push_byte(8'h01);
      push_byte(8'hff);

      // random frames across the idling phases
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 84; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 84; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         while (sent_bytes < (p + 1) * PHASE_BYTES) push_frame();
      end

      // huge 64-bit length with the top bit set, masked; only a few payload bytes follow
      push_byte(8'h82);
      push_byte({1'b1, LEN_EXT64});
      repeat (8) push_byte(8'hff);
      repeat (4) push_byte(8'($urandom_range(255)));
      repeat (8) push_byte(8'($urandom_range(255)));
      req_tvalid <= 1'b0;

      while (board.pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== websocket_frame_deframer.f =====
src/wsd_pkg.sv
src/wsd_front.sv
src/wsd_queue.sv
src/wsd_back.sv
src/websocket_frame_deframer.sv
tb/websocket_frame_deframer_tb.sv
